// ===== rtl/core/mctd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-channel touch detector package
// Shared widths, constants, record layout, sequencer states and the
// structs that pass between the detector's submodules.
// ----------------------------------------------------------------------------
package mctd_pkg;

   // Channel and sample geometry.
   localparam int CHANNELS    = 7;
   localparam int CAL_SAMPLES = 32;
   localparam int CH_W        = 3;
   localparam int SAMPLE_W    = 22;
   localparam int COUNT_W     = $clog2(CAL_SAMPLES + 1);
   localparam int SUM_W       = SAMPLE_W + $clog2(CAL_SAMPLES);
   localparam int FRAC_W      = 4;
   localparam int LEVEL_W     = SAMPLE_W + FRAC_W;
   localparam int DELTA_W     = SAMPLE_W;
   localparam int THRESH_W    = 22;
   localparam int POWER_W     = 12;
   localparam int SCAN_W      = $clog2(CHANNELS + 1);

   localparam logic [THRESH_W-1:0] THRESH_RESET = 22'd1500;

   // Smoothing: 7*level + 48*raw fits in four bits above the level width,
   // and the divide by ten is a multiply by ceil(2^33/10) and a shift.
   localparam int ACC_W       = LEVEL_W + 4;
   localparam int RECIP_W     = 30;
   localparam int DIV10_SHIFT = 33;
   localparam int PROD10_W    = ACC_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV10_RECIP = 30'd858993460;

   // Power: floor(delta*4095/10000) saturates at 4095 from delta 10000 up.
   // Below that it is delta times ceil(4095*2^28/10000), shifted by 28.
   localparam int SAT_W        = 14;
   localparam int PSCALE_W     = 27;
   localparam int PSCALE_SHIFT = 28;
   localparam int PPROD_W      = SAT_W + PSCALE_W;
   localparam logic [PSCALE_W-1:0] PSCALE_MULT     = 27'd109924320;
   localparam logic [DELTA_W-1:0]  POWER_SAT_DELTA = 22'd10000;
   localparam logic [POWER_W-1:0]  POWER_MAX       = 12'd4095;

   // Stream and register port widths.
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_TOUCH_THRESHOLD = 1'b0;

   // One channel's stored state.
   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] baseline;
      logic [LEVEL_W-1:0]  smoothed;
      logic [DELTA_W-1:0]  delta;
      logic                active;
   } rec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_WRITE,
      ST_SCAN,
      ST_SCALE,
      ST_DONE
   } state_type;

   // Step strobes from the sequencer.
   typedef struct packed {
      logic accept;
      logic load;
      logic div;
      logic write;
      logic scan_start;
      logic scan_step;
      logic scale;
   } ctrl_type;

   // Outcome of the channel update.
   typedef struct packed {
      logic                in_range;
      logic [CH_W-1:0]     ch;
      logic                calibrated;
      logic [DELTA_W-1:0]  delta;
      logic                active;
   } upd_type;

   // Summary over all channels.
   typedef struct packed {
      logic                any_active;
      logic [POWER_W-1:0]  power;
      logic [CH_W-1:0]     leader;
   } summ_type;

endpackage

// ===== rtl/core/mctd_csr.sv =====
// ----------------------------------------------------------------------------
// Touch detector register port
// Holds the touch threshold register behind a simple APB-style port.
// ----------------------------------------------------------------------------
module mctd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mctd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mctd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mctd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [mctd_pkg::THRESH_W-1:0]       threshold
);
   import mctd_pkg::*;

   logic [THRESH_W-1:0]  thresh_ff;
   logic [THRESH_W-1:0]  thresh_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_hit;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign threshold  = thresh_ff;

   // Write decode; writes to unknown registers are dropped.
   always_comb begin
      thresh_in = thresh_ff;
      if (wr_hit) begin
         unique case (reg_idx)
            REG_TOUCH_THRESHOLD: thresh_in = csr_pwdata[THRESH_W-1:0];
            default: thresh_in = thresh_ff;
         endcase
      end
   end

   // Read decode.
   always_comb begin
      unique case (reg_idx)
         REG_TOUCH_THRESHOLD: csr_prdata = CSR_DATA_W'(thresh_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

endmodule

// ===== rtl/core/mctd_chan_mem.sv =====
// ----------------------------------------------------------------------------
// Touch detector channel memory
// One record per channel in a synchronous memory with registered read data.
// Per-entry valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module mctd_chan_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mctd_pkg::CH_W-1:0]   rd_addr,
   output mctd_pkg::rec_type           rd_rec,
   input  logic                        wr_en,
   input  logic [mctd_pkg::CH_W-1:0]   wr_addr,
   input  mctd_pkg::rec_type           wr_rec
);
   import mctd_pkg::*;

   rec_type             mem [CHANNELS];
   rec_type             rd_data_ff;
   logic                rd_hit_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic                rd_hit_in;

   // An address past the last channel never hits.
   assign rd_hit_in = |(valid_ff & (CHANNELS'(1) << rd_addr));
   assign rd_rec    = rd_hit_ff ? rd_data_ff : '0;

   // Storage array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_rec;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Valid bits are cleared by reset and set on the first write.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         rd_hit_ff <= rd_hit_in;
         if (wr_en) begin
            valid_ff <= valid_ff | (CHANNELS'(1) << wr_addr);
         end
      end
   end

endmodule

// ===== rtl/core/mctd_update.sv =====
// ----------------------------------------------------------------------------
// Touch detector channel update
// Read-modify-write datapath for one sample: calibration sum, baseline,
// exponential smoothing, delta and threshold compare.
// ----------------------------------------------------------------------------
module mctd_update (
   input  logic                          clock,
   input  mctd_pkg::ctrl_type            ctrl,
   input  logic [mctd_pkg::CH_W-1:0]     req_channel,
   input  logic [mctd_pkg::SAMPLE_W-1:0] req_raw,
   input  mctd_pkg::rec_type             rd_rec,
   input  logic [mctd_pkg::THRESH_W-1:0] threshold,
   output logic                          wr_en,
   output logic [mctd_pkg::CH_W-1:0]     wr_addr,
   output mctd_pkg::rec_type             wr_rec,
   output mctd_pkg::upd_type             upd
);
   import mctd_pkg::*;

   logic [CH_W-1:0]     ch_ff;
   logic [SAMPLE_W-1:0] raw_ff;
   rec_type             rec_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [PROD10_W-1:0] prod_ff;
   upd_type             upd_ff;

   logic                in_range;
   logic                calibrating;
   logic [ACC_W-1:0]    acc_in;
   logic [SUM_W-1:0]    sum_next;
   logic [COUNT_W-1:0]  count_next;
   logic [LEVEL_W-1:0]  quot;
   logic [SAMPLE_W-1:0] whole;
   logic [SAMPLE_W-1:0] base_next;
   rec_type             new_rec;
   upd_type             upd_in;

   assign in_range    = 32'(ch_ff) < CHANNELS;
   assign calibrating = rec_ff.count < COUNT_W'(CAL_SAMPLES);

   // 7*level + 48*raw, built from shifts.
   assign acc_in = (ACC_W'(rd_rec.smoothed) << 3) - ACC_W'(rd_rec.smoothed)
                 + (ACC_W'(raw_ff) << 5) + (ACC_W'(raw_ff) << 4);

   // Quotient by ten out of the reciprocal product, then its integer part.
   assign quot  = prod_ff[DIV10_SHIFT +: LEVEL_W];
   assign whole = quot[FRAC_W +: SAMPLE_W];

   assign sum_next   = rec_ff.sum + SUM_W'(raw_ff);
   assign count_next = rec_ff.count + COUNT_W'(1);
   assign base_next  = SAMPLE_W'(sum_next / CAL_SAMPLES);

   // New record for the channel.
   always_comb begin
      new_rec = rec_ff;
      if (calibrating) begin
         new_rec.sum   = sum_next;
         new_rec.count = count_next;
         if (count_next == COUNT_W'(CAL_SAMPLES)) begin
            new_rec.baseline = base_next;
            new_rec.smoothed = {base_next, FRAC_W'(0)};
            new_rec.delta    = '0;
            new_rec.active   = 1'b0;
         end
      end else begin
         new_rec.smoothed = quot;
         new_rec.delta    = (whole > rec_ff.baseline) ? (whole - rec_ff.baseline) : '0;
         new_rec.active   = new_rec.delta > threshold;
      end
   end

   // Result fields of this beat; an out-of-range channel reports zeros.
   always_comb begin
      upd_in.in_range   = in_range;
      upd_in.ch         = ch_ff;
      upd_in.calibrated = in_range && (new_rec.count >= COUNT_W'(CAL_SAMPLES));
      upd_in.delta      = in_range ? new_rec.delta : '0;
      upd_in.active     = in_range && new_rec.active;
   end

   assign wr_en   = ctrl.write && in_range;
   assign wr_addr = ch_ff;
   assign wr_rec  = new_rec;
   assign upd     = upd_ff;

   // Datapath registers, one group per step.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         ch_ff  <= req_channel;
         raw_ff <= req_raw;
      end
      if (ctrl.load) begin
         rec_ff <= rd_rec;
         acc_ff <= acc_in;
      end
      if (ctrl.div) begin
         prod_ff <= PROD10_W'(acc_ff) * PROD10_W'(DIV10_RECIP);
      end
      if (ctrl.write) begin
         upd_ff <= upd_in;
      end
   end

endmodule

// ===== rtl/core/mctd_summary.sv =====
// ----------------------------------------------------------------------------
// Touch detector summary scan
// Walks the channel memory one entry per cycle to find any active channel,
// the leader with the largest delta and its scaled power.
// ----------------------------------------------------------------------------
module mctd_summary (
   input  logic                      clock,
   input  mctd_pkg::ctrl_type        ctrl,
   input  logic [mctd_pkg::CH_W-1:0] cmp_idx,
   input  mctd_pkg::rec_type         rd_rec,
   input  mctd_pkg::upd_type         upd,
   output mctd_pkg::summ_type        summ
);
   import mctd_pkg::*;

   logic               any_ff;
   logic [DELTA_W-1:0] best_ff;
   logic [CH_W-1:0]    leader_ff;
   logic               sat_ff;
   logic [PPROD_W-1:0] pprod_ff;

   logic               fwd;
   logic [DELTA_W-1:0] cur_delta;
   logic               cur_active;
   logic               take;

   // The freshly updated channel comes from the update result, since its
   // memory read may predate the write-back.
   assign fwd        = upd.in_range && (upd.ch == cmp_idx);
   assign cur_delta  = fwd ? upd.delta : rd_rec.delta;
   assign cur_active = fwd ? upd.active : rd_rec.active;
   assign take       = cur_active && (!any_ff || (cur_delta >= best_ff));

   // Running maximum; ascending scan so ties go to the higher index.
   always_ff @(posedge clock) begin
      if (ctrl.scan_start) begin
         any_ff    <= 1'b0;
         best_ff   <= '0;
         leader_ff <= '0;
      end else if (ctrl.scan_step) begin
         any_ff <= any_ff || cur_active;
         if (take) begin
            best_ff   <= cur_delta;
            leader_ff <= cmp_idx;
         end
      end
      if (ctrl.scale) begin
         sat_ff   <= best_ff >= POWER_SAT_DELTA;
         pprod_ff <= PPROD_W'(best_ff[SAT_W-1:0]) * PPROD_W'(PSCALE_MULT);
      end
   end

   // Power is monotonic in delta, so the leader's delta gives the maximum.
   always_comb begin
      summ.any_active = any_ff;
      summ.power      = sat_ff ? POWER_MAX : pprod_ff[PSCALE_SHIFT +: POWER_W];
      summ.leader     = leader_ff;
   end

endmodule

// ===== rtl/core/multi_channel_touch_detector_core.sv =====
// ----------------------------------------------------------------------------
// Multi-channel touch detector core
// Per-channel baseline calibration and smoothing with a summary over all
// channels, one result beat for every sample beat.
// ----------------------------------------------------------------------------
// Each sample runs a read-modify-write of the channel record (load, divide,
//   write), then a summary scan that reads the channel memory once per
//   channel, then power scaling and the output handoff; no new sample is
//   taken until that sequence is through.
// A new sample is taken while the previous result still waits on rsp_tready.
// Reset clears the sequencer, the output valid and all channel valid bits,
//   so every channel starts uncalibrated; the threshold returns to 1500.
// ----------------------------------------------------------------------------
module multi_channel_touch_detector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [21:0] raw_sample, [23:22] zero
   input  logic [mctd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] channel
   input  logic [mctd_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] calibrated, [22:1] channel_delta, [23] channel_active,
   // [24] any_active, [36:25] strongest_power, [37] leader_valid,
   // [40:38] leader_channel, [47:41] zero
   output logic [mctd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mctd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mctd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mctd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import mctd_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   logic [SCAN_W-1:0]  scan_ff;
   logic [SCAN_W-1:0]  scan_in;
   logic [SCAN_W-1:0]  scan_prev;
   logic               rsp_tvalid_ff;
   upd_type            rsp_upd_ff;
   summ_type           rsp_summ_ff;

   ctrl_type           ctrl;
   logic               out_load;
   logic [CH_W-1:0]    rd_addr;
   logic [CH_W-1:0]    cmp_idx;
   logic [THRESH_W-1:0] threshold;
   rec_type            rd_rec;
   logic               wr_en;
   logic [CH_W-1:0]    wr_addr;
   rec_type            wr_rec;
   upd_type            upd;
   summ_type           summ;

   assign scan_prev = scan_ff - SCAN_W'(1);
   assign cmp_idx   = CH_W'(scan_prev);

   // Register port.
   mctd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold)
   );

   // Channel record memory.
   mctd_chan_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_rec  (rd_rec),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_rec  (wr_rec)
   );

   // Read-modify-write of the addressed channel.
   mctd_update u_update (
      .clock       (clock),
      .ctrl        (ctrl),
      .req_channel (req_tuser[CH_W-1:0]),
      .req_raw     (req_tdata[SAMPLE_W-1:0]),
      .rd_rec      (rd_rec),
      .threshold   (threshold),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_rec      (wr_rec),
      .upd         (upd)
   );

   // Scan over all channels.
   mctd_summary u_summary (
      .clock   (clock),
      .ctrl    (ctrl),
      .cmp_idx (cmp_idx),
      .rd_rec  (rd_rec),
      .upd     (upd),
      .summ    (summ)
   );

   // Sequencer: next state, step strobes and memory read address.
   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      ctrl       = '0;
      out_load   = 1'b0;
      req_tready = 1'b0;
      rd_addr    = CH_W'(scan_ff);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = req_tuser[CH_W-1:0];
            if (req_tvalid) begin
               ctrl.accept = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctrl.load = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ctrl.write      = 1'b1;
            ctrl.scan_start = 1'b1;
            rd_addr         = '0;
            scan_in         = SCAN_W'(1);
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            ctrl.scan_step = 1'b1;
            if (scan_ff == SCAN_W'(CHANNELS)) begin
               state_in = ST_SCALE;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         ST_SCALE: begin
            ctrl.scale = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   // Output register; it holds a result beat until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_upd_ff  <= upd;
         rsp_summ_ff <= summ;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_summ_ff.leader,
                        rsp_summ_ff.any_active,
                        rsp_summ_ff.power,
                        rsp_summ_ff.any_active,
                        rsp_upd_ff.active,
                        rsp_upd_ff.delta,
                        rsp_upd_ff.calibrated};

`ifndef ASSERT_OFF
   // The memory is never written beyond the last channel.
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < CHANNELS))
      else $error("channel memory written out of range");

   // A result beat only appears from the handoff state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside the handoff state");

   // The scan counter stays within the channel range while scanning.
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((scan_ff != '0) && (scan_ff <= SCAN_W'(CHANNELS))))
      else $error("scan counter out of range");

   // Without an active channel, power and leader must be zero.
   a_idle_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_summ_ff.any_active)
         |-> ((rsp_summ_ff.power == '0) && (rsp_summ_ff.leader == '0)))
      else $error("summary fields set with no active channel");
`endif

endmodule

// ===== tb/multi_channel_touch_detector_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-channel touch detector core testbench
// Drives raw touch samples into the core over its sample stream and checks
// every result beat against a cycle-free behavioral copy of the detector:
// per-channel calibration, Q22.4 smoothing, deltas, active flags and the
// summary over all channels. The threshold register is reprogrammed between
// phases over the register port, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module multi_channel_touch_detector_core_tb;
   import mctd_pkg::*;

   localparam int          DRAIN_CYCLES  = 16;
   localparam int          STALL_LIMIT   = 3000;
   localparam int          POWER_DIVISOR = 10000;
   localparam int          PHASE_BEATS   = 200;
   localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = '1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE  = 1'b1;

   // One result beat, as the detector should report it.
   typedef struct packed {
      logic                calibrated;
      logic [DELTA_W-1:0]  delta;
      logic                active;
      logic                any_active;
      logic [POWER_W-1:0]  power;
      logic                leader_valid;
      logic [CH_W-1:0]     leader;
   } touch_report_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // [21:0] raw_sample, [23:22] zero
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   // [2:0] channel
   logic [REQ_TUSER_W-1:0]  req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [0] calibrated, [22:1] channel_delta, [23] channel_active,
   // [24] any_active, [36:25] strongest_power, [37] leader_valid,
   // [40:38] leader_channel, [47:41] zero
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // Behavioral copy of the detector state.
   logic [COUNT_W-1:0]      cal_taken [CHANNELS];
   logic [SUM_W-1:0]        cal_total [CHANNELS];
   logic [SAMPLE_W-1:0]     base_level [CHANNELS];
   logic [LEVEL_W-1:0]      level_q4 [CHANNELS];
   logic [DELTA_W-1:0]      chan_delta [CHANNELS];
   logic                    chan_touched [CHANNELS];
   logic [THRESH_W-1:0]     threshold_setting = THRESH_RESET;

   touch_report_type        pending_reports [$];
   int                      error_count = 0;
   int                      quiet_cycles = 0;
   logic                    steady_flow = 1'b0;

   multi_channel_touch_detector_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Update the channel that the sample belongs to, then summarize all channels.
   function automatic touch_report_type predict_touch(input logic [CH_W-1:0] ch,
                                                      input logic [SAMPLE_W-1:0] raw);
      touch_report_type    rep;
      logic [63:0]         acc;
      logic [63:0]         scaled;
      logic [SAMPLE_W-1:0] whole;
      logic [POWER_W-1:0]  pwr;
      logic [DELTA_W-1:0]  lead_delta;
      rep = '0;
      lead_delta = '0;
      if (ch < CHANNELS) begin
         if (cal_taken[ch] < CAL_SAMPLES) begin
            cal_total[ch] = cal_total[ch] + raw;
            cal_taken[ch] = cal_taken[ch] + 1'b1;
            // The completing sample sets the baseline and seeds the level.
            if (cal_taken[ch] == CAL_SAMPLES) begin
               base_level[ch] = SAMPLE_W'(cal_total[ch] / CAL_SAMPLES);
               level_q4[ch] = {base_level[ch], 4'b0000};
               chan_delta[ch] = '0;
               chan_touched[ch] = 1'b0;
            end
         end else begin
            acc = 64'(level_q4[ch]) * 7 + 64'(raw) * 48;
            level_q4[ch] = LEVEL_W'(acc / 10);
            whole = level_q4[ch][LEVEL_W-1:FRAC_W];
            chan_delta[ch] = (whole > base_level[ch]) ? whole - base_level[ch] : '0;
            chan_touched[ch] = chan_delta[ch] > threshold_setting;
         end
         rep.calibrated = cal_taken[ch] == CAL_SAMPLES;
         rep.delta = chan_delta[ch];
         rep.active = chan_touched[ch];
      end
      // Strongest power and leader over active channels; ties go upward.
      for (int i = 0; i < CHANNELS; i++) begin
         if (chan_touched[i]) begin
            scaled = 64'(chan_delta[i]) * POWER_MAX / POWER_DIVISOR;
            pwr = (scaled >= POWER_MAX) ? POWER_MAX : scaled[POWER_W-1:0];
            if (pwr > rep.power)
               rep.power = pwr;
            if (!rep.any_active || chan_delta[i] >= lead_delta) begin
               lead_delta = chan_delta[i];
               rep.leader = CH_W'(i);
            end
            rep.any_active = 1'b1;
         end
      end
      rep.leader_valid = rep.any_active;
      return rep;
   endfunction

   // A level plus a signed offset, held inside the sample range.
   function automatic logic [SAMPLE_W-1:0] near_level(input logic [SAMPLE_W-1:0] level,
                                                      input int offset);
      longint v;
      v = longint'(level) + offset;
      if (v < 0)
         v = 0;
      if (v > longint'(SAMPLE_MAX))
         v = longint'(SAMPLE_MAX);
      return SAMPLE_W'(v);
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Offer one sample beat, after a random gap, and hold it until it is taken.
   task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] raw);
      while (!steady_flow && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= ch;
      req_tdata <= {2'b00, raw};
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(predict_touch(ch, raw));
   endtask

   // Stop sending and let every expected result arrive.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register transfer: setup cycle, then access until pready.
   task automatic csr_transfer(input logic [CSR_IDX_W-1:0] idx, input logic wr,
                               input logic [CSR_DATA_W-1:0] wdata, input logic keep_sel,
                               output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_penable <= 1'b0;
      if (!keep_sel)
         csr_psel <= 1'b0;
   endtask

   // Write a register while the core is idle and read the threshold back.
   task automatic program_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      wait_for_drain();
      csr_transfer(idx, 1'b1, value, 1'b1, rd);
      if (idx == REG_TOUCH_THRESHOLD)
         threshold_setting = value[THRESH_W-1:0];
      csr_transfer(REG_TOUCH_THRESHOLD, 1'b0, '0, 1'b0, rd);
      compare_field("touch_threshold readback", 32'(threshold_setting), rd);
   endtask

   // Samples for a channel index past the last channel, before any baseline.
   task automatic test_out_of_range();
      send_sample(3'd7, SAMPLE_MAX);
      send_sample(3'd7, '0);
      send_sample(3'd7, SAMPLE_W'($urandom));
   endtask

   // Calibrate every channel: flat zero, flat full scale, two equal flat
   // channels for leader ties, and three noisy channels at random levels.
   task automatic test_calibration();
      logic [SAMPLE_W-1:0] cal_level [CHANNELS];
      logic [SAMPLE_W-1:0] raw;
      for (int ch = 0; ch < CHANNELS; ch++)
         cal_level[ch] = SAMPLE_W'($urandom_range(3000000));
      cal_level[0] = '0;
      cal_level[1] = SAMPLE_MAX;
      cal_level[2] = 22'd1000;
      cal_level[5] = 22'd1000;
      for (int s = 0; s < CAL_SAMPLES; s++) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            if (ch == 3 || ch == 4 || ch == 6)
               raw = near_level(cal_level[ch], int'($urandom_range(800)) - 400);
            else
               raw = cal_level[ch];
            send_sample(CH_W'(ch), raw);
         end
      end
   endtask

   // Threshold extremes, equal deltas, saturated power, stale active flags
   // after a threshold change, and a write to an unused register.
   task automatic test_threshold_extremes();
      program_register(REG_TOUCH_THRESHOLD, '0);
      send_sample(3'd2, 22'd1001);
      send_sample(3'd2, 22'd1100);
      send_sample(3'd5, 22'd1001);
      send_sample(3'd5, 22'd1100);
      send_sample(3'd0, SAMPLE_MAX);
      send_sample(3'd7, 22'd12345);
      program_register(REG_TOUCH_THRESHOLD, 32'(SAMPLE_MAX));
      send_sample(3'd0, SAMPLE_MAX);
      send_sample(3'd1, SAMPLE_MAX);
      send_sample(3'd1, '0);
      program_register(REG_SPARE, '1);
      send_sample(3'd2, '0);
      send_sample(3'd6, SAMPLE_MAX);
   endtask

   // Phases of random traffic: a pressed channel gets touch-sized samples,
   // the others mostly sit near their baselines, with some noise beats.
   task automatic test_random_traffic();
      logic [CH_W-1:0]       press_ch;
      logic [CH_W-1:0]       ch;
      logic [SAMPLE_W-1:0]   raw;
      logic [CSR_DATA_W-1:0] level;
      int                    press_depth;
      int                    pick;
      press_ch = '0;
      press_depth = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: level = 32'(THRESH_RESET);
            1: level = '0;
            2: level = $urandom_range(3000);
            3: level = $urandom;
            4: level = 32'(SAMPLE_MAX);
            default: level = $urandom_range(200, 12000);
         endcase
         program_register(REG_TOUCH_THRESHOLD, level);
         steady_flow = (phase == 5);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n == 0 || $urandom_range(19) == 0) begin
               press_ch = CH_W'($urandom_range(CHANNELS - 1));
               press_depth = $urandom_range(30000);
            end
            pick = $urandom_range(99);
            if (pick < 3)
               ch = 3'd7;
            else if (pick < 43)
               ch = press_ch;
            else
               ch = CH_W'($urandom_range(CHANNELS - 1));
            pick = $urandom_range(99);
            if (ch >= CHANNELS)
               raw = SAMPLE_W'($urandom);
            else if (ch == press_ch)
               raw = near_level(base_level[ch], press_depth + int'($urandom_range(400)) - 200);
            else if (pick < 80)
               raw = near_level(base_level[ch], int'($urandom_range(400)) - 200);
            else if (pick < 87)
               raw = '0;
            else if (pick < 94)
               raw = SAMPLE_MAX;
            else
               raw = SAMPLE_W'($urandom);
            send_sample(ch, raw);
         end
      end
      steady_flow = 1'b0;
   endtask

   // Result side: random backpressure and a check of every result beat.
   always @(posedge clock) begin
      touch_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               error_count++;
               $display("%0t: result beat with none expected, expected nothing, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = pending_reports.pop_front();
               compare_field("calibrated", want.calibrated, rsp_tdata[0]);
               compare_field("channel_delta", want.delta, rsp_tdata[22:1]);
               compare_field("channel_active", want.active, rsp_tdata[23]);
               compare_field("any_active", want.any_active, rsp_tdata[24]);
               compare_field("strongest_power", want.power, rsp_tdata[36:25]);
               compare_field("leader_valid", want.leader_valid, rsp_tdata[37]);
               compare_field("leader_channel", want.leader, rsp_tdata[40:38]);
            end
         end
         rsp_tready <= steady_flow || ($urandom_range(99) >= 34);
      end
   end

   // Watchdog: too many cycles in a row without any beat or register access.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("** multi_channel_touch_detector_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         cal_taken[ch] = '0;
         cal_total[ch] = '0;
         base_level[ch] = '0;
         level_q4[ch] = '0;
         chan_delta[ch] = '0;
         chan_touched[ch] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_out_of_range();
      test_calibration();
      test_threshold_extremes();
      test_random_traffic();
      wait_for_drain();
      if (error_count == 0)
         $display("** multi_channel_touch_detector_core: PASSED **");
      else
         $display("** multi_channel_touch_detector_core: FAILED **");
      $finish;
   end

endmodule
